// ----- rtl/core/byte_pattern_find_replace_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the byte pattern find and replace block
// Clocked, reset-qualified concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_FIND_REPLACE_ASSERT_SVH
`define BYTE_PATTERN_FIND_REPLACE_ASSERT_SVH

// Full form: explicit clock and active-low reset
`define BPFR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Short form: uses clk_i and rst_ni of the enclosing scope
`define BPFR_ASSERT(lbl, prop, msg) \
  `BPFR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/bpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfr_pkg
// Shared constants and types of the byte pattern find and replace block.
// ----------------------------------------------------------------------------
package bpfr_pkg;

  // Default window depth in bytes
  localparam int MAX_PATTERN_BYTES_DEF = 24;
  // Bytes held by the three packed pattern words
  localparam int PACKED_BYTES = 24;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_C = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEN    = 3'd6;

  // Per-cell control from the window controller
  typedef struct packed {
    logic pop;     // shift towards the head
    logic load;    // take the incoming byte
    logic cmp_en;  // cell lies inside the pattern length
    logic repl;    // overwrite with the replacement byte
  } cell_ctrl_t;

endpackage

// ----- rtl/core/bpfr_if.sv -----
// ----------------------------------------------------------------------------
// bpfr_if
// Valid/ready stream interfaces for input bytes and result bytes.
// ----------------------------------------------------------------------------
interface bpfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface bpfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       found;

  modport source (output valid, output out_byte, output out_last, output found,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input found,
                  output ready);
endinterface

// ----- rtl/core/bpfr_cell.sv -----
// ----------------------------------------------------------------------------
// bpfr_cell
// One window position: holds a byte, compares it and shifts it on.
// ----------------------------------------------------------------------------
module bpfr_cell
  import bpfr_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] new_byte_i,
  input  logic [7:0] nbr_byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic [7:0] rep_byte_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q, byte_d;
  logic [7:0] val;

  // Window content after this cycle's shift and append
  always_comb begin
    if (ctrl_i.load) begin
      val = new_byte_i;
    end else if (ctrl_i.pop) begin
      val = nbr_byte_i;
    end else begin
      val = byte_q;
    end
    byte_d = ctrl_i.repl ? rep_byte_i : val;
  end

  // Cells beyond the pattern length never veto a match
  assign match_o = !ctrl_i.cmp_en || (val == pat_byte_i);

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ----- rtl/core/byte_pattern_find_replace.sv -----
// ----------------------------------------------------------------------------
// byte_pattern_find_replace
// Streaming byte search: first match of the pattern is overwritten.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle in steady state, while the result side is ready.
// Output: a byte moves to the result register on the first pop after the transaction
//   that fills the window behind it, i.e. L-1 input bytes after its own.
// On stream_end the window drains one byte per cycle through the result register,
//   while the result side is ready; input is taken again in the cycle the final byte goes out.
// Reset: control and configuration clear at once (length to 1); no clearing pass.
module byte_pattern_find_replace
  import bpfr_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bpfr_in_if.sink               in_ch,
  bpfr_out_if.source            out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int WIN   = (MAX_PATTERN_BYTES < PACKED_BYTES) ? MAX_PATTERN_BYTES
                                                            : PACKED_BYTES;
  localparam int CNT_W = $clog2(WIN + 1);

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_a_q, pat_b_q, pat_c_q;
  logic [CFG_DATA_W-1:0] rep_a_q, rep_b_q, rep_c_q;
  logic [LEN_W-1:0]      plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_a_q <= '0;
      pat_b_q <= '0;
      pat_c_q <= '0;
      rep_a_q <= '0;
      rep_b_q <= '0;
      rep_c_q <= '0;
      plen_q  <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAT_A:  pat_a_q <= cfg_data_i;
        REG_PAT_B:  pat_b_q <= cfg_data_i;
        REG_PAT_C:  pat_c_q <= cfg_data_i;
        REG_REPL_A: rep_a_q <= cfg_data_i;
        REG_REPL_B: rep_b_q <= cfg_data_i;
        REG_REPL_C: rep_c_q <= cfg_data_i;
        REG_LEN:    plen_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [3*CFG_DATA_W-1:0] pat_vec, rep_vec;
  assign pat_vec = {pat_c_q, pat_b_q, pat_a_q};
  assign rep_vec = {rep_c_q, rep_b_q, rep_a_q};

  // Effective length clamped to 1 .. WIN
  logic [CNT_W-1:0] len_eff;
  always_comb begin
    if (plen_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (32'(plen_q) > 32'(WIN)) begin
      len_eff = CNT_W'(WIN);
    end else begin
      len_eff = CNT_W'(plen_q);
    end
  end

  // Window control state
  logic [CNT_W-1:0] fill_q, pend_q;
  logic             md_q, flush_q;
  logic             out_valid_q, out_last_q, found_q;
  logic [7:0]       out_byte_q;

  logic             out_free, pop, fin_pop, accept, in_ready;
  logic             md_e, do_cmp, all_match, repl;
  logic [CNT_W-1:0] fill_e, pend_new;
  logic [CNT_W:0]   fill_new;

  logic [7:0]       win_byte [WIN];
  logic [WIN-1:0]   match_vec;

  assign out_free = !out_valid_q || out_ch.ready;
  assign pop      = (pend_q != '0) && out_free;
  assign fin_pop  = pop && flush_q && (pend_q == CNT_W'(1));
  assign in_ready = (pend_q == '0) || ((pend_q == CNT_W'(1)) && out_free);
  assign accept   = in_ch.valid && in_ready;

  // State as seen by the incoming byte, after this cycle's pop
  assign fill_e   = fill_q - CNT_W'(pop);
  assign md_e     = fin_pop ? 1'b0 : md_q;
  assign fill_new = {1'b0, fill_e} + (CNT_W+1)'(1);

  assign do_cmp    = (fill_new == {1'b0, len_eff}) && !md_e;
  assign all_match = &match_vec;
  assign repl      = accept && do_cmp && all_match;

  // Bytes to emit for the accepted transaction
  always_comb begin
    if (in_ch.stream_end) begin
      pend_new = fill_new[CNT_W-1:0];
    end else if (fill_new >= {1'b0, len_eff}) begin
      pend_new = CNT_W'(fill_new - {1'b0, len_eff} + (CNT_W+1)'(1));
    end else begin
      pend_new = '0;
    end
  end

  // Row of window cells, head at index 0
  for (genvar k = 0; k < WIN; k++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] nbr;

    assign ctrl.pop    = pop;
    assign ctrl.load   = accept && (fill_e == CNT_W'(k));
    assign ctrl.cmp_en = CNT_W'(k) < len_eff;
    assign ctrl.repl   = repl;

    if (k == WIN - 1) begin : g_tail
      assign nbr = win_byte[k];
    end else begin : g_mid
      assign nbr = win_byte[k+1];
    end

    bpfr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_byte_i (in_ch.data_byte),
      .nbr_byte_i (nbr),
      .pat_byte_i (pat_vec[8*k +: 8]),
      .rep_byte_i (rep_vec[8*k +: 8]),
      .byte_o     (win_byte[k]),
      .match_o    (match_vec[k])
    );
  end

  // Fill, pending count and stream flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      pend_q  <= '0;
      md_q    <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      md_q <= md_e | repl;
      if (accept) begin
        fill_q  <= fill_new[CNT_W-1:0];
        pend_q  <= pend_new;
        flush_q <= in_ch.stream_end;
      end else begin
        fill_q  <= fill_e;
        pend_q  <= pend_q - CNT_W'(pop);
        if (fin_pop) begin
          flush_q <= 1'b0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q <= win_byte[0];
      out_last_q <= flush_q && (pend_q == CNT_W'(1));
      found_q    <= md_q;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_q;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.out_last = out_last_q;
  assign out_ch.found    = found_q;

endmodule

// ----- rtl/core/bpfr_checker.sv -----
// ----------------------------------------------------------------------------
// bpfr_checker
// Port-level checks of the find and replace block, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_pattern_find_replace_assert.svh"

module bpfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i
);

  logic       in_acc, out_acc, out_wait;
  logic [7:0] inflight_q;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_acc  = out_valid_i && out_ready_i;
  assign out_wait = out_valid_i && !out_ready_i;

  // Bytes taken in and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  `BPFR_ASSERT(a_out_hold, out_wait |=> out_valid_i && $stable(out_byte_i), "stalled result lost")
  `BPFR_ASSERT(a_stall_cause, !in_ready_i |=> out_valid_i, "input stalled with no result")
  `BPFR_ASSERT(a_no_invent, out_valid_i |-> inflight_q != 8'd0, "result with no byte in flight")

endmodule

bind byte_pattern_find_replace bpfr_checker u_bpfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_byte_i  (out_ch.out_byte)
);
